// ----- rtl/poi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// poi_pkg
// Shared constants, types and command structures for the odometry integrator.
// ----------------------------------------------------------------------------
package poi_pkg;

  localparam int ANGLE_BITS = 32;
  localparam int POS_BITS   = 48;

  localparam logic [31:0] SIN_A  = 32'd1686629713;
  localparam logic [31:0] SIN_B  = 32'd688904866;
  localparam logic [31:0] SIN_C  = 32'd76016977;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [21:0] HEAD_K = 22'd2799883;
  localparam logic [27:0] DT_RND = 28'd65536000;

  // divide by 2^20 * 125: shift by DT_SH, then multiply by ceil(2^41 / 125)
  localparam int          DT_SH  = 20;
  localparam logic [34:0] DT_RCP = 35'd17592186045;
  localparam int          RCP_SH = 41;

  typedef enum logic [3:0] {
    OP_IDLE, OP_LOAD, OP_Z2, OP_T1, OP_T2, OP_T3, OP_SIN, OP_PROJ, OP_MAG,
    OP_SCALE, OP_RLO, OP_RHI, OP_HEAD, OP_COMMIT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic sel;
  } poi_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/poi_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// poi_in_if / poi_out_if
// Valid/ready channels for velocity requests and pose results.
// ----------------------------------------------------------------------------
interface poi_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] vel_forward;
  logic signed [15:0] vel_lateral;
  logic signed [15:0] yaw_rate;
  logic [19:0]        elapsed_us;
  modport source (output valid, vel_forward, vel_lateral, yaw_rate, elapsed_us,
                  input ready);
  modport sink   (input valid, vel_forward, vel_lateral, yaw_rate, elapsed_us,
                  output ready);
endinterface

interface poi_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] pos_x;
  logic signed [47:0] pos_y;
  logic [31:0]        heading;
  logic signed [15:0] out_vel_forward;
  logic signed [15:0] out_vel_lateral;
  logic signed [15:0] out_yaw_rate;
  modport source (output valid, pos_x, pos_y, heading, out_vel_forward,
                  out_vel_lateral, out_yaw_rate, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, out_vel_forward,
                  out_vel_lateral, out_yaw_rate, output ready);
endinterface
`default_nettype wire

// ----- rtl/poi_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// poi_ctrl
// Sequencer: steps the datapath through sine, cosine, projection and update.
// ----------------------------------------------------------------------------
module poi_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output poi_pkg::poi_cmd_t      cmd
);
  import poi_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_Z2, S_T1, S_T2, S_T3, S_SIN, S_PROJ, S_MAG, S_SCALE, S_RLO,
    S_RHI, S_HEAD, S_COMMIT, S_OUT
  } state_t;

  state_t state;
  logic   sel;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd.sel = sel;
    unique case (state)
      S_IDLE:   cmd.op = (in_valid) ? OP_LOAD : OP_IDLE;
      S_Z2:     cmd.op = OP_Z2;
      S_T1:     cmd.op = OP_T1;
      S_T2:     cmd.op = OP_T2;
      S_T3:     cmd.op = OP_T3;
      S_SIN:    cmd.op = OP_SIN;
      S_PROJ:   cmd.op = OP_PROJ;
      S_MAG:    cmd.op = OP_MAG;
      S_SCALE:  cmd.op = OP_SCALE;
      S_RLO:    cmd.op = OP_RLO;
      S_RHI:    cmd.op = OP_RHI;
      S_HEAD:   cmd.op = OP_HEAD;
      S_COMMIT: cmd.op = OP_COMMIT;
      default:  cmd.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE:  if (in_valid) begin
          state <= S_Z2;
          sel   <= 1'b0;
        end
        S_Z2:    state <= S_T1;
        S_T1:    state <= S_T2;
        S_T2:    state <= S_T3;
        S_T3:    state <= S_SIN;
        S_SIN:   begin
          if (sel) begin
            state <= S_PROJ;
            sel   <= 1'b0;
          end else begin
            state <= S_Z2;
            sel   <= 1'b1;
          end
        end
        S_PROJ:  state <= S_MAG;
        S_MAG:   state <= S_SCALE;
        S_SCALE: state <= S_RLO;
        S_RLO:   state <= S_RHI;
        S_RHI:   begin
          if (sel) begin
            state <= S_HEAD;
            sel   <= 1'b0;
          end else begin
            state <= S_MAG;
            sel   <= 1'b1;
          end
        end
        S_HEAD:   state <= S_COMMIT;
        S_COMMIT: state <= S_OUT;
        S_OUT:    if (out_ready) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/poi_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// poi_dp
// Datapath: rotation, a shared multiplier for the sine polynomial, a
// reciprocal multiply for the micrometre scaling, and the pose registers.
// ----------------------------------------------------------------------------
module poi_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire poi_pkg::poi_cmd_t  cmd,
  input  wire logic               enable,
  input  wire logic signed [15:0] vel_forward,
  input  wire logic signed [15:0] vel_lateral,
  input  wire logic signed [15:0] yaw_rate,
  input  wire logic [19:0]        elapsed_us,
  output logic signed [47:0]      pos_x,
  output logic signed [47:0]      pos_y,
  output logic [31:0]             heading,
  output logic signed [15:0]      out_vel_forward,
  output logic signed [15:0]      out_vel_lateral,
  output logic signed [15:0]      out_yaw_rate
);
  import poi_pkg::*;

  localparam logic signed [POS_BITS-1:0] PMAX = {1'b0, {(POS_BITS-1){1'b1}}};
  localparam logic signed [POS_BITS-1:0] PMIN = {1'b1, {(POS_BITS-1){1'b0}}};
  localparam int SH = 56 - ANGLE_BITS;

  logic signed [POS_BITS-1:0]   pose_x, pose_y;
  logic [ANGLE_BITS-1:0]        pose_heading;
  logic signed [15:0]           prev_vf, prev_vl;
  logic signed [15:0]           vf, vl, yr;
  logic [19:0]                  dt;
  logic signed [16:0]           sx, sy;
  logic [30:0]                  z, z2, t;
  logic                         neg_s;
  logic signed [31:0]           sn, cs;
  logic signed [49:0]           px, py;
  logic                         pneg;
  logic [36:0]                  m;
  logic [33:0]                  qs;
  logic [51:0]                  acc;
  logic [35:0]                  ymag;
  logic                         yneg;
  logic [ANGLE_BITS-1:0]        dh;
  logic signed [POS_BITS:0]     dx, dy;

  logic [31:0]  hq;
  logic [31:0]  hcos;
  logic [61:0]  prod;
  logic signed [49:0] p_sel;
  logic [49:0]  p_abs;
  logic [27:0]  dmag;
  logic signed [35:0] yd;
  logic [35:0]  y_abs;
  logic signed [POS_BITS:0] sum_x, sum_y, dsel;

  function automatic logic signed [POS_BITS-1:0] sat(
    input logic signed [POS_BITS:0] v
  );
    logic signed [POS_BITS:0] hi, lo;
    hi = {PMAX[POS_BITS-1], PMAX};
    lo = {PMIN[POS_BITS-1], PMIN};
    if (v > hi)      sat = PMAX;
    else if (v < lo) sat = PMIN;
    else             sat = v[POS_BITS-1:0];
  endfunction

  assign hq   = {pose_heading, {(32-ANGLE_BITS){1'b0}}};
  assign hcos = hq + 32'h4000_0000;

  always_comb begin
    case (cmd.op)
      OP_Z2:    prod = {31'd0, z} * {31'd0, z};
      OP_T1:    prod = {30'd0, SIN_C} * {31'd0, z2};
      OP_T2:    prod = {31'd0, t} * {31'd0, z2};
      OP_T3:    prod = {31'd0, t} * {31'd0, z};
      OP_SCALE: prod = {25'd0, m} * {42'd0, dt};
      OP_RLO:   prod = {45'd0, qs[16:0]} * {27'd0, DT_RCP};
      OP_RHI:   prod = {45'd0, qs[33:17]} * {27'd0, DT_RCP};
      OP_HEAD:  prod = {26'd0, ymag} * {40'd0, HEAD_K};
      default:  prod = '0;
    endcase
  end

  assign p_sel = cmd.sel ? py : px;
  assign p_abs = p_sel[49] ? 50'd0 - p_sel : p_sel;
  assign dmag  = 28'(({prod[51:0], 17'd0} + {17'd0, acc}) >> RCP_SH);

  assign yd    = yr * $signed({1'b0, dt});
  assign y_abs = yd[35] ? 36'd0 - yd : yd;

  assign dsel  = pneg ? -$signed((POS_BITS+1)'(dmag)) :
                 $signed((POS_BITS+1)'(dmag));
  assign sum_x = $signed({pose_x[POS_BITS-1], pose_x}) + dx;
  assign sum_y = $signed({pose_y[POS_BITS-1], pose_y}) + dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x       <= '0;
      pose_y       <= '0;
      pose_heading <= '0;
      prev_vf      <= '0;
      prev_vl      <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          vf <= enable ? vel_forward : 16'sd0;
          vl <= enable ? vel_lateral : 16'sd0;
          yr <= enable ? yaw_rate : 16'sd0;
          dt <= elapsed_us;
          sx <= (enable ? 17'(vel_forward) : 17'sd0) + 17'(prev_vf);
          sy <= (enable ? 17'(vel_lateral) : 17'sd0) + 17'(prev_vl);
          z  <= hq[30] ? Q30_ONE - {1'b0, hq[29:0]} : {1'b0, hq[29:0]};
          neg_s <= hq[31];
        end
        OP_Z2: z2 <= 31'(prod >> 30);
        OP_T1: t  <= 31'({1'b0, SIN_B} - 33'(prod >> 30));
        OP_T2: t  <= 31'({1'b0, SIN_A} - 33'(prod >> 30));
        OP_T3: begin
          if (cmd.sel) cs <= neg_s ? -$signed({1'b0, prod[60:30]}) :
                                     $signed({1'b0, prod[60:30]});
          else         sn <= neg_s ? -$signed({1'b0, prod[60:30]}) :
                                     $signed({1'b0, prod[60:30]});
        end
        OP_SIN: begin
          z     <= hcos[30] ? Q30_ONE - {1'b0, hcos[29:0]} : {1'b0, hcos[29:0]};
          neg_s <= hcos[31];
        end
        OP_PROJ: begin
          px   <= 50'(sx * cs) - 50'(sy * sn);
          py   <= 50'(sx * sn) + 50'(sy * cs);
          ymag <= y_abs;
          yneg <= yd[35];
        end
        OP_MAG: begin
          m    <= 37'((p_abs + 50'd8192) >> 14);
          pneg <= p_sel[49];
        end
        OP_SCALE: qs  <= 34'((prod + 62'(DT_RND)) >> DT_SH);
        OP_RLO:   acc <= 52'(prod);
        OP_RHI: begin
          if (cmd.sel) dy <= dsel;
          else         dx <= dsel;
        end
        OP_HEAD: dh <= ANGLE_BITS'((prod + (62'd1 << (SH - 1))) >> SH);
        OP_COMMIT: begin
          pose_x       <= sat(sum_x);
          pose_y       <= sat(sum_y);
          pose_heading <= yneg ? pose_heading - dh : pose_heading + dh;
          prev_vf      <= vf;
          prev_vl      <= vl;
        end
        default: ;
      endcase
    end
  end

  assign pos_x           = pose_x;
  assign pos_y           = pose_y;
  assign heading         = 32'(pose_heading);
  assign out_vel_forward = vf;
  assign out_vel_lateral = vl;
  assign out_yaw_rate    = yr;

endmodule
`default_nettype wire

// ----- rtl/planar_odometry_integrator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// planar_odometry_integrator
// Dead-reckoning pose integrator with midpoint translation.
// ----------------------------------------------------------------------------
// One request at a time: after acceptance the sequencer runs the sine and cosine
// through the shared multiplier, one projection step, the x and y scaling (each:
// magnitude, times elapsed time, two-part reciprocal multiply) and the heading
// and pose update, and then raises the result. The result holds until taken;
// the next request can be accepted in the cycle after that, so a new request
// is not taken before the last result is gone.
module planar_odometry_integrator (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata,
  poi_in_if.sink    req,
  poi_out_if.source rsp
);
  import poi_pkg::*;

  logic     enable;
  poi_cmd_t cmd;

  always_ff @(posedge clk) begin
    if (rst) enable <= 1'b0;
    else if (cfg_we) enable <= cfg_wdata;
  end

  poi_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (req.valid),
    .in_ready (req.ready),
    .out_valid(rsp.valid),
    .out_ready(rsp.ready),
    .cmd
  );

  poi_dp u_dp (
    .clk, .rst, .cmd, .enable,
    .vel_forward    (req.vel_forward),
    .vel_lateral    (req.vel_lateral),
    .yaw_rate       (req.yaw_rate),
    .elapsed_us     (req.elapsed_us),
    .pos_x          (rsp.pos_x),
    .pos_y          (rsp.pos_y),
    .heading        (rsp.heading),
    .out_vel_forward(rsp.out_vel_forward),
    .out_vel_lateral(rsp.out_vel_lateral),
    .out_yaw_rate   (rsp.out_yaw_rate)
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid)) else $error("accept while result pending");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> $stable(rsp.pos_x) && $stable(rsp.heading))
    else $error("result changed while stalled");
  a_accept_clears: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready && !rsp.valid)
    else $error("request not taken into work");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/poi_pose_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poi_pose_checker
// Watches the request and result channels of the odometry integrator,
// predicts each pose result from the accepted requests and the enable
// register, and compares the results field by field in order.
// ----------------------------------------------------------------------------
module poi_pose_checker (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata,
  poi_in_if         req,
  poi_out_if        rsp,
  output int        pending,
  output int        errors
);

  typedef struct packed {
    logic [47:0] pos_x;
    logic [47:0] pos_y;
    logic [31:0] heading;
    logic [15:0] vel_forward;
    logic [15:0] vel_lateral;
    logic [15:0] yaw_rate;
  } pose_t;

  localparam longint POS_MAX = (64'sd1 <<< 47) - 1;
  localparam longint POS_MIN = -POS_MAX - 1;
  localparam logic [63:0] SIN_A = 64'd1686629713;
  localparam logic [63:0] SIN_B = 64'd688904866;
  localparam logic [63:0] SIN_C = 64'd76016977;
  localparam logic [63:0] HEAD_K = 64'd2799883;

  bit          enable;
  longint      x_acc, y_acc;
  logic [31:0] yaw_acc;
  int          last_vf, last_vl;
  pose_t       pose_q[$];

  function automatic longint sine_q30(logic [31:0] h);
    logic [63:0] z, z2, t;
    z = {34'd0, h[29:0]};
    if (h[30]) z = (64'd1 << 30) - z;
    z2 = (z * z) >> 30;
    t = (SIN_C * z2) >> 30;
    t = SIN_B - t;
    t = (t * z2) >> 30;
    t = SIN_A - t;
    t = (t * z) >> 30;
    return h[31] ? -longint'(t) : longint'(t);
  endfunction

  function automatic longint step_delta(longint p, logic [63:0] dt);
    logic [63:0] mag, m, d;
    mag = p < 0 ? -p : p;
    m = (mag + 64'd8192) >> 14;
    d = (m * dt + 64'd65536000) / 64'd131072000;
    return p < 0 ? -longint'(d) : longint'(d);
  endfunction

  function automatic longint clamp_add(longint pose, longint d);
    if (d > 0 && pose > POS_MAX - d) return POS_MAX;
    if (d < 0 && pose < POS_MIN - d) return POS_MIN;
    return pose + d;
  endfunction

  function automatic pose_t integrate(int vf, int vl, int yr, logic [19:0] dt);
    pose_t       r;
    longint      sn, cs, sx, sy, yd;
    logic [63:0] ymag, dh;
    if (!enable) begin
      vf = 0; vl = 0; yr = 0;
    end
    sn = sine_q30(yaw_acc);
    cs = sine_q30(yaw_acc + 32'h4000_0000);
    sx = vf + last_vf;
    sy = vl + last_vl;
    x_acc = clamp_add(x_acc, step_delta(sx * cs - sy * sn, {44'd0, dt}));
    y_acc = clamp_add(y_acc, step_delta(sx * sn + sy * cs, {44'd0, dt}));
    yd = longint'(yr) * longint'(dt);
    ymag = yd < 0 ? -yd : yd;
    dh = (ymag * HEAD_K + (64'd1 << 23)) >> 24;
    yaw_acc = yd < 0 ? yaw_acc - dh[31:0] : yaw_acc + dh[31:0];
    last_vf = vf;
    last_vl = vl;
    r.pos_x = x_acc[47:0];
    r.pos_y = y_acc[47:0];
    r.heading = yaw_acc;
    r.vel_forward = vf[15:0];
    r.vel_lateral = vl[15:0];
    r.yaw_rate = yr[15:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    pose_t want;
    if (rst) begin
      enable <= 1'b0;
      x_acc = 0; y_acc = 0; yaw_acc = 0; last_vf = 0; last_vl = 0;
      pose_q.delete();
      pending = 0;
      errors = 0;
    end else begin
      if (req.valid && req.ready)
        pose_q = {pose_q, integrate(req.vel_forward, req.vel_lateral, req.yaw_rate,
                                    req.elapsed_us)};
      if (rsp.valid && rsp.ready) begin
        if (pose_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual x=%0h y=%0h", $time,
                   rsp.pos_x, rsp.pos_y);
        end else begin
          want = pose_q.pop_front();
          check_field("pos_x", want.pos_x, $unsigned(rsp.pos_x));
          check_field("pos_y", want.pos_y, $unsigned(rsp.pos_y));
          check_field("heading", want.heading, rsp.heading);
          check_field("out_vel_forward", want.vel_forward,
                      $unsigned(rsp.out_vel_forward));
          check_field("out_vel_lateral", want.vel_lateral,
                      $unsigned(rsp.out_vel_lateral));
          check_field("out_yaw_rate", want.yaw_rate, $unsigned(rsp.out_yaw_rate));
        end
      end
      if (cfg_we) enable <= cfg_wdata;
      pending = pose_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_planar_odometry_integrator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_planar_odometry_integrator
// Drives velocity requests and enable settings into the odometry integrator
// under varying idle patterns and a long result stall; the pose checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_planar_odometry_integrator;

  localparam int CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;
  int   pending;
  int   errors;
  int   cycles;
  int   send_idle;
  int   recv_idle;
  bit   long_hold_req;
  bit   long_hold_done;
  int   hold_left;

  poi_in_if  req();
  poi_out_if rsp();

  planar_odometry_integrator u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp)
  );

  poi_pose_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp),
    .pending   (pending),
    .errors    (errors)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      hold_left <= 0;
      long_hold_done <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      hold_left <= 700;
      long_hold_done <= 1'b1;
      rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= $urandom_range(99) >= recv_idle;
    end
  end

  task automatic send(int vf, int vl, int yr, int dt);
    while ($urandom_range(99) < send_idle) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.vel_forward <= vf[15:0];
    req.vel_lateral <= vl[15:0];
    req.yaw_rate <= yr[15:0];
    req.elapsed_us <= dt[19:0];
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic drain_and_set(bit en);
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random(int count);
    repeat (count) begin
      if ($urandom_range(3) != 0)
        send($urandom_range(4000) - 2000, $urandom_range(4000) - 2000,
             $urandom_range(16000) - 8000, $urandom_range(100000, 5000));
      else
        send($urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    cycles = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    long_hold_req = 1'b0;
    send_idle = 28;
    recv_idle = 82;
    req.valid = 1'b0;
    req.vel_forward = '0;
    req.vel_lateral = '0;
    req.yaw_rate = '0;
    req.elapsed_us = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(1000, -500, 2000, 20000);
    send(-32768, 32767, -32768, 1048575);
    drain_and_set(1'b1);
    send(32767, 32767, 32767, 1048575);
    send(-32768, -32768, -32768, 1048575);
    send(1000, 1000, 12000, 0);
    send(0, 0, 0, 0);
    send(32767, -32768, 32767, 1);
    send(-1, 1, -1, 1048575);
    send(2000, 0, 32767, 1048575);
    send(2000, 0, 32767, 1048575);
    send(2000, 0, 32767, 1048575);
    send(-2000, 300, -32768, 500000);
    send(1500, -1500, 6433, 250000);
    drain_and_set(1'b0);
    send(5000, 5000, 5000, 100000);
    send(5000, 5000, 5000, 100000);
    drain_and_set(1'b1);
    send(-32768, 32767, 4096, 1048575);
    send(32767, -32768, -4096, 0);

    send_random(300);
    drain_and_set(1'b0);
    send_idle = 82;
    recv_idle = 28;
    send_random(60);
    drain_and_set(1'b1);
    send_random(260);
    drain_and_set(1'b1);
    send_idle = 0;
    recv_idle = 0;
    long_hold_req = 1'b1;
    send_random(330);
    req.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/poi_pkg.sv
rtl/poi_if.sv
rtl/poi_ctrl.sv
rtl/poi_dp.sv
rtl/planar_odometry_integrator.sv
tb/sv/poi_pose_checker.sv
tb/sv/tb_planar_odometry_integrator.sv
